// ===== sv/chbd_pkg.sv =====
package chbd_pkg;

  typedef enum logic [2:0] {
    PH_SIZE   = 3'd0,
    PH_SKIPLF = 3'd1,
    PH_DATA   = 3'd2,
    PH_TRAIL1 = 3'd3,
    PH_TRAIL2 = 3'd4,
    PH_DONE   = 3'd5,
    PH_HALT   = 3'd6
  } phase_t;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [3:0] HEX_TEN   = 4'd10;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       bad;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Digits and either letter case are accepted; anything else comes back with ok low.
  function automatic hex_t hex_decode(input logic [7:0] ch);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      h.val = 4'(ch - CH_ZERO);
    end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
      h.val = 4'(ch - CH_UP_A) + HEX_TEN;
    end else if (ch >= CH_LO_A && ch <= CH_LO_F) begin
      h.val = 4'(ch - CH_LO_A) + HEX_TEN;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== sv/chbd_fsm.sv =====
module chbd_fsm #(
  parameter int SIZE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        byte_in,
  output chbd_pkg::res_t    res
);

  chbd_pkg::phase_t     phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] count_r, count_nxt;
  logic [SIZE_BITS-1:0] count_dec;
  chbd_pkg::hex_t       hx;

  assign hx        = chbd_pkg::hex_decode(byte_in);
  assign count_dec = count_r - SIZE_BITS'(1);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    case (phase_r)
      chbd_pkg::PH_SIZE: begin
        if (byte_in == chbd_pkg::CH_CR) begin
          phase_nxt = (count_r == '0) ? chbd_pkg::PH_DONE : chbd_pkg::PH_SKIPLF;
        end else if (!hx.ok) begin
          phase_nxt = chbd_pkg::PH_HALT;
        end else begin
          count_nxt = {count_r[SIZE_BITS-5:0], hx.val};
        end
      end
      chbd_pkg::PH_SKIPLF: phase_nxt = chbd_pkg::PH_DATA;
      chbd_pkg::PH_DATA: begin
        count_nxt = count_dec;
        if (count_dec == '0) phase_nxt = chbd_pkg::PH_TRAIL1;
      end
      chbd_pkg::PH_TRAIL1: phase_nxt = chbd_pkg::PH_TRAIL2;
      chbd_pkg::PH_TRAIL2: begin
        phase_nxt = chbd_pkg::PH_SIZE;
        count_nxt = '0;
      end
      chbd_pkg::PH_DONE: phase_nxt = chbd_pkg::PH_DONE;
      default: phase_nxt = chbd_pkg::PH_HALT;
    endcase
  end

  // result for the current item
  always_comb begin
    res = '0;
    case (phase_r)
      chbd_pkg::PH_SIZE: begin
        if (byte_in == chbd_pkg::CH_CR) begin
          res.valid = (count_r == '0);
          res.done  = (count_r == '0);
        end else if (!hx.ok) begin
          res.valid = 1'b1;
          res.bad   = 1'b1;
        end
      end
      chbd_pkg::PH_DATA: begin
        res.valid = 1'b1;
        res.data  = byte_in;
        res.last  = (count_dec == '0);
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= chbd_pkg::PH_SIZE;
      count_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == chbd_pkg::PH_DONE || phase_r == chbd_pkg::PH_HALT) |-> !res.valid)
    else $error("result emitted after body end or halt");

  a_last_to_trail: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.last |=> phase_r == chbd_pkg::PH_TRAIL1 && count_r == '0)
    else $error("chunk end did not enter trailer");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == chbd_pkg::PH_DATA |-> count_r != '0)
    else $error("payload phase with zero count");
`endif

endmodule

// ===== sv/chbd_out_reg.sv =====
module chbd_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  chbd_pkg::res_t res,
  input  logic           out_tready,
  output logic           out_tvalid,
  output logic [7:0]     out_tdata,
  output logic           out_tlast,
  output logic [1:0]     out_tuser
);

  logic       valid_r;
  logic [7:0] data_r;
  logic       last_r;
  logic [1:0] user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res.valid;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res.data;
      last_r <= res.last;
      user_r <= {res.bad, res.done};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = user_r;

endmodule

// ===== sv/http_chunked_body_decoder.sv =====
// Path: an accepted byte is held in the input register; the step that takes it loads its
// result into the result register, and a result still held there stalls that step.
// Throughput: one byte per cycle unless the output stalls; phase and count update on each step.
// Bytes that cause no result still take a step in the step stage.
// Reset (rst_n low, synchronous): empties both registers, phase to size line,
// count to zero.
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_byte
  output logic       out_tlast,  // chunk_last
  output logic [1:0] out_tuser   // [0] body_done, [1] bad_size
);

  logic           in_valid_r;
  logic [7:0]     in_byte_r;
  logic           step;
  chbd_pkg::res_t res;

  // step the decoder when a byte is held and the result register can take it
  assign step      = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_byte_r <= in_tdata;
  end

  chbd_fsm #(.SIZE_BITS(SIZE_BITS)) u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_byte_r),
    .res     (res)
  );

  chbd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
